// ===== src/xbr_pkg.sv =====
// Shared types and constants for the xoshiro128** bounded random unit.
`timescale 1ns / 1ps
package xbr_pkg;

  // Datapath operations
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_CAPTURE    = 4'd1;
  localparam logic [3:0] OP_STEP       = 4'd2;
  localparam logic [3:0] OP_DIV_THR    = 4'd3;
  localparam logic [3:0] OP_DIV_DRAW   = 4'd4;
  localparam logic [3:0] OP_DIV_STEP   = 4'd5;
  localparam logic [3:0] OP_THR_SAVE   = 4'd6;
  localparam logic [3:0] OP_SEED_ADD   = 4'd7;
  localparam logic [3:0] OP_XSHIFT     = 4'd8;
  localparam logic [3:0] OP_MUL0       = 4'd9;
  localparam logic [3:0] OP_MUL1       = 4'd10;
  localparam logic [3:0] OP_MUL2       = 4'd11;
  localparam logic [3:0] OP_STORE      = 4'd12;
  localparam logic [3:0] OP_FIX        = 4'd13;
  localparam logic [3:0] OP_OUT        = 4'd14;

  // Result source for OP_OUT
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_RAW  = 2'd1;
  localparam logic [1:0] SEL_REM  = 2'd2;

  // Request kinds
  localparam logic [1:0] FUNC_RAW     = 2'd0;
  localparam logic [1:0] FUNC_BOUNDED = 2'd1;
  localparam logic [1:0] FUNC_RESEED  = 2'd2;

  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

  localparam int unsigned DIV_STEPS = 32;

  typedef struct packed {
    logic [3:0] op;
    logic       mix_b;
    logic [1:0] idx;
    logic [1:0] sel;
  } xbr_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       bound_small;
    logic       below_thr;
  } xbr_status_t;

endpackage

// ===== src/xoshiro128ss_bounded_random_unit.sv =====
// Top level of the xoshiro128** bounded random unit with SplitMix64 reseed.
`timescale 1ns / 1ps
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  func[1:0], bound[31:0], seed_value[63:0]
//  out      source     out_valid/out_ready  value[31:0]
//
//  Work per request: a bounded draw runs two 32-step restoring divisions on one
//  shared remainder unit, with a new draw for each rejected one; a reseed runs
//  four SplitMix64 mixes, each two 64-bit products built from three passes
//  through one 32x32 multiplier.
//  Reset: rst clears control and sets the generator state to word0 = 1, rest 0.
//  Stalls: a new transaction is taken while a finished result waits in the
//  output register; the next result holds in its final state until that is taken.
module xoshiro128ss_bounded_random_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] bound,
  input  logic [63:0] seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);
  import xbr_pkg::*;

  // Command and status buses between the sequencer and the datapath
  xbr_cmd_t    cmd;
  xbr_status_t status;

  // Sequencer: owns the state machine, step counters and the result handshake
  xbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: generator words, divider, multiplier, output register
  xbr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .bound      (bound),
    .seed_value (seed_value),
    .status     (status),
    .value      (value)
  );

endmodule

// ===== src/xbr_dp.sv =====
// Datapath: generator state, shared divider, shared 32x32 multiplier, result register.
`timescale 1ns / 1ps
module xbr_dp (
  input  logic               clk,
  input  logic               rst,
  input  xbr_pkg::xbr_cmd_t  cmd,
  input  logic [1:0]         func,
  input  logic [31:0]        bound,
  input  logic [63:0]        seed_value,
  output xbr_pkg::xbr_status_t status,
  output logic [31:0]        value
);
  import xbr_pkg::*;

  logic [31:0] gen_words [4];
  logic [1:0]  func_q;
  logic [31:0] bound_q;
  logic [63:0] sm;
  logic [63:0] z;
  logic [63:0] acc;
  logic [31:0] r;
  logic [31:0] thr;
  logic [31:0] rem;
  logic [31:0] dvd;

  logic [31:0] w1x5;
  logic [31:0] raw_out;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] seed_sum;
  logic [63:0] zs_out;
  logic        all_zero;

  assign w1x5    = (gen_words[1] << 2) + gen_words[1];
  assign raw_out = ({w1x5[24:0], w1x5[31:25]} << 3) + {w1x5[24:0], w1x5[31:25]};

  assign rem_sh = {rem, dvd[31]};
  assign diff   = rem_sh - {1'b0, bound_q};

  assign mul_c = cmd.mix_b ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        mul_a = z[31:0];
        mul_b = mul_c[63:32];
      end
      OP_MUL2: begin
        mul_a = z[63:32];
        mul_b = mul_c[31:0];
      end
      default: begin
        mul_a = z[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign seed_sum = sm + GOLDEN_INC;
  assign zs_out   = z ^ (z >> 31);
  assign all_zero = (gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 32'd0;

  assign status.func        = func_q;
  assign status.bound_small = bound_q < 32'd2;
  assign status.below_thr   = r < thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_words[0] <= 32'd1;
      gen_words[1] <= 32'd0;
      gen_words[2] <= 32'd0;
      gen_words[3] <= 32'd0;
    end else begin
      case (cmd.op)
        OP_STEP: begin
          gen_words[0] <= gen_words[0] ^ gen_words[3] ^ gen_words[1];
          gen_words[1] <= gen_words[1] ^ gen_words[2] ^ gen_words[0];
          gen_words[2] <= gen_words[2] ^ gen_words[0] ^ (gen_words[1] << 9);
          gen_words[3] <= {gen_words[3][20:0] ^ gen_words[1][20:0],
                           gen_words[3][31:21] ^ gen_words[1][31:21]};
        end
        OP_STORE: gen_words[cmd.idx] <= zs_out[63:32];
        OP_FIX: begin
          if (all_zero) begin
            gen_words[0] <= 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        func_q  <= func;
        bound_q <= bound;
        sm      <= seed_value;
      end
      OP_STEP: r <= raw_out;
      OP_DIV_THR: begin
        dvd <= 32'd0 - bound_q;
        rem <= 32'd0;
      end
      OP_DIV_DRAW: begin
        dvd <= r;
        rem <= 32'd0;
      end
      OP_DIV_STEP: begin
        dvd <= dvd << 1;
        rem <= diff[32] ? rem_sh[31:0] : diff[31:0];
      end
      OP_THR_SAVE: thr <= rem;
      OP_SEED_ADD: begin
        sm <= seed_sum;
        z  <= seed_sum;
      end
      OP_XSHIFT: z <= cmd.mix_b ? (z ^ (z >> 27)) : (z ^ (z >> 30));
      OP_MUL0: acc <= prod;
      OP_MUL1: acc[63:32] <= acc[63:32] + prod[31:0];
      OP_MUL2: z <= {acc[63:32] + prod[31:0], acc[31:0]};
      OP_OUT: begin
        case (cmd.sel)
          SEL_RAW: value <= r;
          SEL_REM: value <= rem;
          default: value <= 32'd0;
        endcase
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP) |-> !all_zero)
    else $error("generator state is all zero at a step");
  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_STEP) |=> (rem < bound_q))
    else $error("partial remainder not below bound");
  a_fix_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIX) |=> !all_zero)
    else $error("reseed left an all-zero state");
`endif

endmodule

// ===== src/xbr_ctrl.sv =====
// Controller: sequences requests, divider steps, seed expansion and the result handshake.
`timescale 1ns / 1ps
module xbr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  xbr_pkg::xbr_status_t status,
  output xbr_pkg::xbr_cmd_t    cmd
);
  import xbr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_THR_DIV  = 4'd2;
  localparam logic [3:0] S_THR_SAVE = 4'd3;
  localparam logic [3:0] S_DRAW     = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_MOD_DIV  = 4'd6;
  localparam logic [3:0] S_SEED_ADD = 4'd7;
  localparam logic [3:0] S_XSHIFT   = 4'd8;
  localparam logic [3:0] S_MUL0     = 4'd9;
  localparam logic [3:0] S_MUL1     = 4'd10;
  localparam logic [3:0] S_MUL2     = 4'd11;
  localparam logic [3:0] S_STORE    = 4'd12;
  localparam logic [3:0] S_FIX      = 4'd13;
  localparam logic [3:0] S_FINISH   = 4'd14;

  localparam logic [4:0] CNT_LAST = 5'(DIV_STEPS - 1);

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] idx, idx_next;
  logic       mix_b, mix_b_next;
  logic [1:0] sel, sel_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    mix_b_next     = mix_b;
    sel_next       = sel;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = OP_NONE;
    cmd.mix_b      = mix_b;
    cmd.idx        = idx;
    cmd.sel        = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.func)
          FUNC_RAW: begin
            cmd.op     = OP_STEP;
            sel_next   = SEL_RAW;
            state_next = S_FINISH;
          end
          FUNC_BOUNDED: begin
            if (status.bound_small) begin
              sel_next   = SEL_ZERO;
              state_next = S_FINISH;
            end else begin
              cmd.op     = OP_DIV_THR;
              cnt_next   = 5'd0;
              state_next = S_THR_DIV;
            end
          end
          FUNC_RESEED: begin
            idx_next   = 2'd0;
            sel_next   = SEL_ZERO;
            state_next = S_SEED_ADD;
          end
          default: begin
            sel_next   = SEL_ZERO;
            state_next = S_FINISH;
          end
        endcase
      end
      S_THR_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == CNT_LAST) begin
          state_next = S_THR_SAVE;
        end
      end
      S_THR_SAVE: begin
        cmd.op     = OP_THR_SAVE;
        state_next = S_DRAW;
      end
      S_DRAW: begin
        cmd.op     = OP_STEP;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.below_thr) begin
          state_next = S_DRAW;
        end else begin
          cmd.op     = OP_DIV_DRAW;
          cnt_next   = 5'd0;
          state_next = S_MOD_DIV;
        end
      end
      S_MOD_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == CNT_LAST) begin
          sel_next   = SEL_REM;
          state_next = S_FINISH;
        end
      end
      S_SEED_ADD: begin
        cmd.op     = OP_SEED_ADD;
        mix_b_next = 1'b0;
        state_next = S_XSHIFT;
      end
      S_XSHIFT: begin
        cmd.op     = OP_XSHIFT;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.op     = OP_MUL0;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = OP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = OP_MUL2;
        if (mix_b) begin
          state_next = S_STORE;
        end else begin
          mix_b_next = 1'b1;
          state_next = S_XSHIFT;
        end
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (idx == 2'd3) begin
          state_next = S_FIX;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_SEED_ADD;
        end
      end
      S_FIX: begin
        cmd.op     = OP_FIX;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= 5'd0;
      idx       <= 2'd0;
      mix_b     <= 1'b0;
      sel       <= SEL_ZERO;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      idx       <= idx_next;
      mix_b     <= mix_b_next;
      sel       <= sel_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted transaction not dispatched");
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside finish");
  a_check_after_draw: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_DRAW))
    else $error("rejection check without a fresh draw");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench for the xoshiro128** bounded random unit: raw, bounded and reseed requests.
`timescale 1ns / 1ps
//
// Stimulus
//   An initial block fills a queue of requests. A short directed list comes first:
//   reset state, small bounds, extreme bounds, the unused request kind, extreme seeds
//   and ignored fields. About nineteen hundred random requests follow. A clocked
//   driver presents the requests on the input channel. Random gaps separate the
//   requests, and some stretches have no gaps at all.
//
// Checking
//   Each accepted request runs through a local model of the generator. The model
//   keeps its own copy of the four state words. The model pushes the expected word
//   into a queue. A clocked monitor takes each result off the output channel. It
//   compares the result with the oldest expected word.
//
// Backpressure
//   The receiver stalls for random lengths after each result. Twice it holds off for
//   LONG_HOLD. During those holds the driver keeps offering requests,
//   so the unit fills up and drops in_ready.
//
module testbench;
  import xbr_pkg::*;

  // The fourth request kind: no state change, and the result is always zero.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned NUM_RANDOM   = 1928;
  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] bound;
    logic [63:0] seed;
  } rng_request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_RAW;
  logic [31:0] bound = '0;
  logic [63:0] seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;

  xoshiro128ss_bounded_random_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .bound      (bound),
    .seed_value (seed_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value)
  );

  rng_request_t pending_reqs[$];
  logic [31:0]  expected_values[$];

  // Local copy of the generator state. It advances only on accepted transactions.
  logic [31:0] gen_state[4] = '{32'd1, 32'd0, 32'd0, 32'd0};

  int unsigned n_offered  = 0;  // requests put on the input port (driver side)
  int unsigned n_accepted = 0;  // input transactions seen at a rising edge
  int unsigned n_results  = 0;  // output transactions seen at a rising edge
  int unsigned n_errors   = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Return the scrambled output, then step the state once.
  function automatic logic [31:0] gen_advance();
    logic [31:0] result;
    logic [31:0] shifted;
    result  = rotl32(gen_state[1] * 32'd5, 7) * 32'd9;
    shifted = gen_state[1] << 9;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= shifted;
    gen_state[3] = rotl32(gen_state[3], 11);
    return result;
  endfunction

  // Use rejection sampling. Keep only draws at or above (2^32 - bound) mod bound.
  // That keeps draw mod bound exactly uniform. Bounds of 0 and 1 give zero and
  // leave the state alone.
  function automatic logic [31:0] gen_bounded(logic [31:0] lim);
    logic [31:0] neg_lim;
    logic [31:0] floor_val;
    logic [31:0] draw;
    if (lim < 32'd2) return 32'd0;
    neg_lim   = 32'd0 - lim;
    floor_val = neg_lim % lim;
    do begin
      draw = gen_advance();
    end while (draw < floor_val);
    return draw % lim;
  endfunction

  // Expand the seed with SplitMix64. Each word keeps the upper half of one mix.
  function automatic void gen_reseed(logic [63:0] s);
    logic [63:0] z;
    for (int i = 0; i < 4; i++) begin
      s = s + GOLDEN_INC;
      z = s;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      z = z ^ (z >> 31);
      gen_state[i] = z[63:32];
    end
    // Never allow an all-zero state. The rejection loop would never end.
    if ((gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]) == 32'd0)
      gen_state[0] = 32'd1;
  endfunction

  function automatic logic [31:0] predict_value(rng_request_t req);
    case (req.func)
      FUNC_RAW:     return gen_advance();
      FUNC_BOUNDED: return gen_bounded(req.bound);
      FUNC_RESEED: begin
        gen_reseed(req.seed);
        return 32'd0;
      end
      default:      return 32'd0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic rng_request_t make_req(logic [1:0] f, logic [31:0] b, logic [63:0] s);
    rng_request_t r;
    r.func  = f;
    r.bound = b;
    r.seed  = s;
    return r;
  endfunction

  // Favor bounds that exercise the corners of the rejection logic. Those are tiny
  // bounds, powers of two, and values near 2^31 where nearly half the draws are
  // rejected. Use full-width values for the rest.
  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1, 2, 3: return $urandom_range(2, 1000);
      4:       return 32'd1 << $urandom_range(0, 31);
      5:       return 32'h8000_0000 + $urandom_range(0, 255);
      6:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic rng_request_t random_req();
    int unsigned pick;
    logic [1:0]  f;
    pick = $urandom_range(0, 99);
    if (pick < 35)      f = FUNC_RAW;
    else if (pick < 80) f = FUNC_BOUNDED;
    else if (pick < 94) f = FUNC_RESEED;
    else                f = FUNC_UNUSED;
    // Randomize the ignored fields as well. The unit must not look at them.
    return make_req(f, pick_bound(), {$urandom, $urandom});
  endfunction

  // Make most gaps zero or short and a few long. Every fourth block of 256
  // transactions runs with no gaps at all.
  function automatic int unsigned pick_gap(int unsigned idx);
    int unsigned p;
    if ((idx / 256) % 4 == 3) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold valid and payload until the
  // transaction is taken. Then insert the chosen gap.
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(negedge clk) begin
    rng_request_t req;
    if (!rst && !(in_valid && n_accepted != n_offered)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        func       <= req.func;
        bound      <= req.bound;
        seed_value <= req.seed;
        in_valid   <= 1'b1;
        n_offered++;
        send_gap = pick_gap(n_offered);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall for a random length after each result. Two long holds make
  // the unit back up into its input channel.
  // ---------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  int unsigned recv_seen  = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (n_results != recv_seen) begin
        recv_seen = n_results;
        if (recv_seen == 150 || recv_seen == 1200) recv_stall = LONG_HOLD;
        else recv_stall = pick_gap(recv_seen + 128);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Predict on each input
  // transaction. Compare each output transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_values.push_back(predict_value(make_req(func, bound, seed_value)));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < MAX_REPORTS)
            $display("result %0d: unexpected value %08h, nothing outstanding",
                     n_results, value);
        end else begin
          want = expected_values.pop_front();
          if (value !== want) begin
            n_errors <= n_errors + 1;
            if (n_errors < MAX_REPORTS)
              $display("result %0d: value expected %08h, got %08h",
                       n_results, want, value);
          end
        end
        n_results <= n_results + 1;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the request queue, release reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    // Start from reset state: the first raw word from (1, 0, 0, 0) is zero.
    pending_reqs.push_back(make_req(FUNC_RAW, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(FUNC_RAW, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(FUNC_RAW, 32'hFFFF_FFFF, '1));
    // Bounds 0 and 1 give zero and leave the state alone; larger and extreme bounds follow.
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd1, '1));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd2, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd3, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'hFFFF_FFFF, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'h8000_0000, 64'd0));
    // At 2^31 + 1 the rejection floor is highest, so nearly half of all draws retry.
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'h8000_0001, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd7, '1));
    // Unused kind with every payload bit set.
    pending_reqs.push_back(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, '1));
    pending_reqs.push_back(make_req(FUNC_RAW, 32'd0, 64'd0));
    // Extreme seeds. The first two are followed by draws from the new state, the last by bounds 1 and 0.
    pending_reqs.push_back(make_req(FUNC_RESEED, 32'hFFFF_FFFF, 64'd0));
    pending_reqs.push_back(make_req(FUNC_RAW, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'h8000_0001, 64'd0));
    pending_reqs.push_back(make_req(FUNC_RESEED, 32'd0, '1));
    pending_reqs.push_back(make_req(FUNC_RAW, 32'hFFFF_FFFF, '1));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd10, '1));
    pending_reqs.push_back(make_req(FUNC_RESEED, 32'd5, 64'h8000_0000_0000_0000));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd1, 64'd0));
    pending_reqs.push_back(make_req(FUNC_BOUNDED, 32'd0, 64'd0));
    for (int i = 0; i < NUM_RANDOM; i++)
      pending_reqs.push_back(random_req());

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every expected result to arrive.
    while (pending_reqs.size() > 0 || n_accepted != n_offered || in_valid ||
           expected_values.size() > 0)
      @(negedge clk);
    // Catch any stray result that comes after the last expected one.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
